// File: hdl/bsm_pkg.sv
// bsm_pkg: shared constants, action codes and controller/datapath command types
// for the button sequence matcher; no dependencies
package bsm_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;
    localparam int PATTERN_COUNT_DEF = 32;
    localparam int BUTTON_BITS_DEF   = 16;

    localparam int BTN_FIELD_W   = 16;
    localparam int TARGET_W      = 5;
    localparam int POS_W         = 4;
    localparam int LEN_W         = 4;
    localparam int ACTION_W      = 2;
    localparam int MATCH_W       = 5;
    localparam int S_TDATA_W     = 64;
    localparam int M_TDATA_W     = 8;

    localparam logic [BTN_FIELD_W-1:0] COMBO_RESET = 16'h0C00;

    localparam logic [ACTION_W-1:0] ACT_PAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STEP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LEN  = 2'd2;

    typedef struct packed {
        logic clr;
        logic accept;
        logic k_clear;
        logic rd;
        logic k_inc;
        logic set_pend;
        logic push_pend;
        logic pat_inc;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic hit;
        logic pat_en;
        logic len_zero;
        logic step_ok;
        logic k_last;
        logic pat_last;
        logic has_pend;
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/button_sequence_matcher.sv
// button_sequence_matcher: top level; unpacks the stream channels and joins
// controller and datapath; depends on bsm_pkg, bsm_ctrl, bsm_dp
//
// Usage:
//   s_axis carries one item per transaction: tuser is the action (0 pad event,
//   1 write pattern step, 2 write pattern length and enable), tdata the operands.
//   m_axis carries one transaction per matched pattern, lowest index first;
//   tlast marks the final match of a pad event. Events that match nothing, do
//   not count, and table writes produce no output.
//   i_cfg_we/i_cfg_wdata write combo_mask; write only while the block is idle.
// Sequence:
//   after reset a clearing pass zeroes every step memory entry with
//   s_axis_tready low. Table writes and non-counting events are accepted in
//   idle and return there. A counted event is accepted, then each pattern is
//   checked in turn: disabled ones are skipped, enabled ones are read and
//   compared step by step (one memory read and one compare per step) until a
//   step fails or all steps match; a final flush hands out the last match.
// Stalls:
//   results sit in an output register; while m_axis_tready is low the scan
//   holds at the next match, and the next item is accepted once the scan ends.
module button_sequence_matcher #(
    parameter int HISTORY_DEPTH = bsm_pkg::HISTORY_DEPTH_DEF,
    parameter int PATTERN_COUNT = bsm_pkg::PATTERN_COUNT_DEF,
    parameter int BUTTON_BITS   = bsm_pkg::BUTTON_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bsm_pkg::BTN_FIELD_W-1:0]    i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // buttons_held, buttons_tapped, target_pattern, step_position, step_buttons,
    // new_length, new_enable, zero fill
    input  logic [bsm_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // action
    input  logic [bsm_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // matched_pattern, zero fill
    output logic [bsm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast
);
    import bsm_pkg::*;

    t_dp_cmd              cmd;
    t_dp_status           sts;
    logic [MATCH_W-1:0]   m_idx;

    bsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bsm_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PATTERN_COUNT (PATTERN_COUNT),
        .BUTTON_BITS   (BUTTON_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_action    (s_axis_tuser),
        .i_held      (s_axis_tdata[15:0]),
        .i_tapped    (s_axis_tdata[31:16]),
        .i_target    (s_axis_tdata[36:32]),
        .i_pos       (s_axis_tdata[40:37]),
        .i_stepb     (s_axis_tdata[56:41]),
        .i_len       (s_axis_tdata[60:57]),
        .i_en        (s_axis_tdata[61]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_idx     (m_idx),
        .o_m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W - MATCH_W){1'b0}}, m_idx};

endmodule

// File: hdl/bsm_dp.sv
// bsm_dp: datapath of the button sequence matcher: tap history, pattern table,
// step memory, scan counters and output register; depends on bsm_pkg
module bsm_dp #(
    parameter int HISTORY_DEPTH = bsm_pkg::HISTORY_DEPTH_DEF,
    parameter int PATTERN_COUNT = bsm_pkg::PATTERN_COUNT_DEF,
    parameter int BUTTON_BITS   = bsm_pkg::BUTTON_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bsm_pkg::BTN_FIELD_W-1:0]     i_cfg_wdata,
    input  logic [bsm_pkg::ACTION_W-1:0]        i_action,
    input  logic [bsm_pkg::BTN_FIELD_W-1:0]     i_held,
    input  logic [bsm_pkg::BTN_FIELD_W-1:0]     i_tapped,
    input  logic [bsm_pkg::TARGET_W-1:0]        i_target,
    input  logic [bsm_pkg::POS_W-1:0]           i_pos,
    input  logic [bsm_pkg::BTN_FIELD_W-1:0]     i_stepb,
    input  logic [bsm_pkg::LEN_W-1:0]           i_len,
    input  logic                                i_en,
    input  bsm_pkg::t_dp_cmd                    i_cmd,
    output bsm_pkg::t_dp_status                 o_sts,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [bsm_pkg::MATCH_W-1:0]         o_m_idx,
    output logic                                o_m_last
);
    import bsm_pkg::*;

    localparam int BTN_W = (BUTTON_BITS < BTN_FIELD_W) ? BUTTON_BITS : BTN_FIELD_W;
    localparam int PW    = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
    localparam int KW    = $clog2(HISTORY_DEPTH);
    localparam int LW    = $clog2(HISTORY_DEPTH + 1);
    localparam int NE    = PATTERN_COUNT * HISTORY_DEPTH;
    localparam int AW    = (NE > 1) ? $clog2(NE) : 1;

    logic [BTN_FIELD_W-1:0] r_combo;
    logic [BTN_W-1:0]       r_hist [HISTORY_DEPTH];
    logic [LW-1:0]          r_len  [PATTERN_COUNT];
    logic                   r_en   [PATTERN_COUNT];
    logic [BTN_W-1:0]       mem    [NE];
    logic [BTN_W-1:0]       r_rd_data;
    logic [AW-1:0]          r_clr;
    logic [PW-1:0]          r_pat;
    logic [KW-1:0]          r_k;
    logic                   r_has_pend;
    logic [PW-1:0]          r_pend;
    logic                   r_out_valid;
    logic [MATCH_W-1:0]     r_out_idx;
    logic                   r_out_last;

    logic [BTN_W-1:0] held_m;
    logic [BTN_W-1:0] tapped_m;
    logic [BTN_W-1:0] need;
    logic [LW-1:0]    len_cur;
    logic [LW-1:0]    step_idx;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    in_addr;
    logic             tgt_ok;
    logic             pos_ok;
    logic [PW-1:0]    tgt_idx;
    logic [LW-1:0]    len_clamp;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [BTN_W-1:0] mem_wd;
    logic             out_free;

    always_comb begin
        held_m    = i_held[BTN_W-1:0];
        tapped_m  = i_tapped[BTN_W-1:0];
        need      = r_combo[BTN_W-1:0];
        len_cur   = r_len[r_pat];
        step_idx  = len_cur - LW'(1) - LW'(r_k);
        rd_addr   = AW'(int'(r_pat) * HISTORY_DEPTH + int'(step_idx));
        in_addr   = AW'(int'(i_target) * HISTORY_DEPTH + int'(i_pos));
        tgt_ok    = int'(i_target) < PATTERN_COUNT;
        pos_ok    = int'(i_pos) < HISTORY_DEPTH;
        tgt_idx   = PW'(i_target);
        len_clamp = (int'(i_len) > HISTORY_DEPTH) ? LW'(HISTORY_DEPTH) : LW'(i_len);
        out_free  = !r_out_valid || i_m_tready;

        mem_we = i_cmd.clr ||
                 (i_cmd.accept && i_action == ACT_STEP && tgt_ok && pos_ok);
        mem_wa = i_cmd.clr ? r_clr : in_addr;
        mem_wd = i_cmd.clr ? '0 : i_stepb[BTN_W-1:0];

        o_sts.clr_done = r_clr == AW'(NE - 1);
        o_sts.hit      = (i_action == ACT_PAD) && ((held_m & need) == need) && (|tapped_m);
        o_sts.pat_en   = r_en[r_pat];
        o_sts.len_zero = len_cur == '0;
        o_sts.step_ok  = |(r_hist[r_k] & r_rd_data);
        o_sts.k_last   = LW'(r_k) == (len_cur - LW'(1));
        o_sts.pat_last = r_pat == PW'(PATTERN_COUNT - 1);
        o_sts.has_pend = r_has_pend;
        o_sts.out_free = out_free;
    end

    // step memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo     <= COMBO_RESET;
            r_clr       <= '0;
            r_pat       <= '0;
            r_k         <= '0;
            r_has_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            for (int i = 0; i < PATTERN_COUNT; i++) begin
                r_len[i] <= '0;
                r_en[i]  <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_combo <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.accept) begin
                if (i_action == ACT_LEN && tgt_ok) begin
                    r_len[tgt_idx] <= len_clamp;
                    r_en[tgt_idx]  <= i_en;
                end
                if (o_sts.hit) begin
                    for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                        r_hist[i] <= r_hist[i-1];
                    end
                    r_hist[0]  <= tapped_m;
                    r_pat      <= '0;
                    r_has_pend <= 1'b0;
                end
            end
            if (i_cmd.k_clear) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.pat_inc) begin
                r_pat <= r_pat + PW'(1);
            end
            if (i_cmd.set_pend || i_cmd.push_pend) begin
                r_has_pend <= 1'b1;
            end else if (i_cmd.flush) begin
                r_has_pend <= 1'b0;
            end
            if (i_cmd.push_pend || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_pend || i_cmd.push_pend) begin
            r_pend <= r_pat;
        end
        if (i_cmd.push_pend || i_cmd.flush) begin
            r_out_idx  <= MATCH_W'(r_pend);
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_idx    = r_out_idx;
    assign o_m_last   = r_out_last;

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_pend || i_cmd.flush) |-> out_free)
        else $error("result pushed into a full output register");

    a_push_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_pend || i_cmd.flush) |-> r_has_pend)
        else $error("result pushed with no pending match");

    a_read_in_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (LW'(r_k) < len_cur))
        else $error("step read beyond pattern length");

    a_event_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !i_cmd.clr)
        else $error("item accepted during memory clear");

endmodule

// File: hdl/bsm_ctrl.sv
// bsm_ctrl: controller of the button sequence matcher; sequences memory clear,
// item acceptance, pattern scan and result hand-off; depends on bsm_pkg
module bsm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  bsm_pkg::t_dp_status  i_sts,
    output bsm_pkg::t_dp_cmd     o_cmd
);
    import bsm_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_CMP   = 8'b0001_0000,
        S_MATCH = 8'b0010_0000,
        S_NEXT  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.hit) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.k_clear = 1'b1;
                if (!i_sts.pat_en) begin
                    n_state = S_NEXT;
                end else if (i_sts.len_zero) begin
                    n_state = S_MATCH;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (!i_sts.step_ok) begin
                    n_state = S_NEXT;
                end else if (i_sts.k_last) begin
                    n_state = S_MATCH;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_MATCH: begin
                if (!i_sts.has_pend) begin
                    o_cmd.set_pend = 1'b1;
                    n_state        = S_NEXT;
                end else if (i_sts.out_free) begin
                    o_cmd.push_pend = 1'b1;
                    n_state         = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.pat_last) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.pat_inc = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_FLUSH: begin
                if (!i_sts.has_pend) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
